>>> hdl/go_to_goal_velocity_core_macros.svh
// Assertion macros for the go-to-goal velocity core.
`ifndef GO_TO_GOAL_VELOCITY_CORE_MACROS_SVH
`define GO_TO_GOAL_VELOCITY_CORE_MACROS_SVH
// implication checked on every clock, off during reset
`define G2G_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// condition that must hold at every clock outside reset
`define G2G_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`endif

>>> hdl/g2g_pkg.sv
// Shared constants and types of the go-to-goal velocity core.
package g2g_pkg;
  localparam int CordicStagesDefault = 16;
  localparam int MaxTable = 24;
  localparam int XW = 32;  // CORDIC x/y datapath width
  localparam int ZW = 29;  // angle accumulator, Q.24
  localparam int PoseW = 16;
  localparam int HeadW = 15;
  localparam int SpeedW = 15;
  localparam int AngW = 15;
  localparam logic signed [ZW-1:0] AngPi = 29'sd52707179;
  localparam logic signed [ZW-1:0] AngTwoPi = 29'sd105414357;
  localparam logic signed [ZW-1:0] AngHalfPi = 29'sd26353589;
  localparam logic [29:0] InvGainQ30 = 30'd652032874;
  localparam logic [SpeedW-1:0] SpeedReset = 15'd2048;

  typedef enum logic [1:0] {
    REG_GOAL_X = 2'd0,
    REG_GOAL_Y = 2'd1,
    REG_MAX_SPEED = 2'd2
  } reg_idx_e;

  // data handed from one cell to the next
  typedef struct packed {
    logic valid;
    logic zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [HeadW-1:0] hd;
  } cell_t;

  function automatic logic signed [ZW-1:0] atan_q24(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 29'sd13176795;
      1: r = 29'sd7778716;
      2: r = 29'sd4110060;
      3: r = 29'sd2086331;
      4: r = 29'sd1047214;
      5: r = 29'sd524117;
      6: r = 29'sd262123;
      7: r = 29'sd131069;
      default: r = ZW'(29'sd1 <<< (24 - i));
    endcase
    return r;
  endfunction
endpackage

>>> hdl/go_to_goal_velocity_core.sv
// Top level of the go-to-goal velocity core.
// One pose sample is taken every cycle (busy_o is always low); its result
// appears on done_o after these registers in order: the entry register,
// which takes the sample at the accepting edge, one cell per CORDIC stage
// (at most MaxTable cells), the gain multiply and the output register.
// The receiver cannot stall, so results are never held.
module go_to_goal_velocity_core #(
  parameter int CORDIC_STAGES = g2g_pkg::CordicStagesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [g2g_pkg::PoseW-1:0]  pose_x_i,
  input  logic signed [g2g_pkg::PoseW-1:0]  pose_y_i,
  input  logic signed [g2g_pkg::HeadW-1:0]  pose_heading_i,
  output logic                              done_o,
  output logic [g2g_pkg::SpeedW-1:0]        linear_speed_o,
  output logic signed [g2g_pkg::AngW-1:0]   angular_rate_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [15:0]                       cfg_data_i
);
  import g2g_pkg::*;
  localparam int NS = (CORDIC_STAGES < MaxTable) ? CORDIC_STAGES : MaxTable;

  logic signed [PoseW-1:0] goal_x_q, goal_y_q;
  logic [SpeedW-1:0] max_speed_q;
  assign cfg_ready_o = 1'b1;
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= '0;
      goal_y_q <= '0;
      max_speed_q <= SpeedReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GOAL_X: goal_x_q <= cfg_data_i;
        REG_GOAL_Y: goal_y_q <= cfg_data_i;
        REG_MAX_SPEED: max_speed_q <= cfg_data_i[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  // entry: error, scale and quadrant turn
  cell_t ent_d;
  cell_t chain [NS+1];
  logic signed [PoseW:0] ex, ey;
  logic signed [XW-1:0] xs, ys;
  always_comb begin
    ey = {goal_y_q[PoseW-1], goal_y_q} - {pose_y_i[PoseW-1], pose_y_i};
    ex = {goal_x_q[PoseW-1], goal_x_q} - {pose_x_i[PoseW-1], pose_x_i};
    xs = XW'(ex) <<< 12;
    ys = XW'(ey) <<< 12;
    ent_d.valid = start_i;
    ent_d.zero = (ex == '0) && (ey == '0);
    ent_d.hd = pose_heading_i;
    ent_d.x = xs;
    ent_d.y = ys;
    ent_d.z = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        ent_d.x = ys; ent_d.y = -xs; ent_d.z = AngHalfPi;
      end else begin
        ent_d.x = -ys; ent_d.y = xs; ent_d.z = -AngHalfPi;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain[0] <= '0;
    end else begin
      chain[0] <= ent_d;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_cell
    g2g_cell #(.Idx(g)) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .cell_i(chain[g]), .cell_o(chain[g+1]));
  end

  // gain removal and angle wrap
  cell_t last;
  assign last = chain[NS];
  logic [XW-2:0] xpos;
  logic [XW+29:0] prod_d, prod_q;
  logic signed [ZW:0] a1, a2;
  logic signed [AngW-1:0] ang_d, ang_q;
  logic v1_q, z1_q;
  always_comb begin
    xpos = last.x[XW-1] ? '0 : last.x[XW-2:0];
    prod_d = (XW+30)'(xpos) * (XW+30)'(InvGainQ30);
    a1 = (ZW+1)'(last.z) - ((ZW+1)'(last.hd) <<< 12);
    if (a1 > (ZW+1)'(AngPi)) a2 = a1 - (ZW+1)'(AngTwoPi);
    else if (a1 <= -(ZW+1)'(AngPi)) a2 = a1 + (ZW+1)'(AngTwoPi);
    else a2 = a1;
    a2 = (a2 + (ZW+1)'(2048)) >>> 12;
    ang_d = last.zero ? '0 : a2[AngW-1:0];
  end

  logic [XW+29:0] magw;
  logic [SpeedW-1:0] spd_d;
  always_comb begin
    magw = (prod_q + ((XW+30)'(1) << 41)) >> 42;
    if (z1_q) spd_d = '0;
    else if (magw > (XW+30)'(max_speed_q)) spd_d = max_speed_q;
    else spd_d = magw[SpeedW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v1_q <= last.valid;
      done_o <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    z1_q <= last.zero;
    ang_q <= ang_d;
    linear_speed_o <= spd_d;
    angular_rate_o <= ang_q;
  end
endmodule

>>> hdl/g2g_cell.sv
// One vectoring CORDIC micro-rotation cell.
module g2g_cell #(
  parameter int Idx = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  g2g_pkg::cell_t  cell_i,
  output g2g_pkg::cell_t  cell_o
);
  import g2g_pkg::*;
  cell_t cell_d, cell_q;
  logic signed [XW-1:0] dx, dy;

  always_comb begin
    dx = cell_i.y >>> Idx;
    dy = cell_i.x >>> Idx;
    cell_d = cell_i;
    if (cell_i.y > 0) begin
      cell_d.x = cell_i.x + dx;
      cell_d.y = cell_i.y - dy;
      cell_d.z = cell_i.z + atan_q24(Idx);
    end else begin
      cell_d.x = cell_i.x - dx;
      cell_d.y = cell_i.y + dy;
      cell_d.z = cell_i.z - atan_q24(Idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end
  assign cell_o = cell_q;
endmodule

>>> hdl/g2g_checker.sv
// Port-level checker for the go-to-goal velocity core, with its bind.
`include "go_to_goal_velocity_core_macros.svh"
module g2g_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [14:0] linear_speed_o,
  input logic [14:0] angular_rate_o,
  input logic        cfg_ready_o
);
  `G2G_ASSERT_ALWAYS(a_never_busy, clk_i, rst_ni, !busy_o)
  `G2G_ASSERT_ALWAYS(a_cfg_ready, clk_i, rst_ni, cfg_ready_o)
  `G2G_ASSERT_IMP(a_speed_known, clk_i, rst_ni, done_o, !$isunknown(linear_speed_o))
  `G2G_ASSERT_IMP(a_ang_range, clk_i, rst_ni, done_o, ($signed(angular_rate_o) <= 15'sd12868) && ($signed(angular_rate_o) >= -15'sd12868))
endmodule

bind go_to_goal_velocity_core g2g_checker u_g2g_checker (.*);
